// ----- design/spq_pkg.sv -----
package spq_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int VAL_W     = 32;
	localparam int ACT_W     = 2;
	localparam int STAT_W    = 2;
	localparam int OP_W      = 2;

	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic [ACT_W-1:0]        action_t;
	typedef logic [STAT_W-1:0]       status_t;
	typedef logic [OP_W-1:0]         op_t;

	// request codes
	localparam action_t ACT_INSERT = 2'd0;
	localparam action_t ACT_DELETE = 2'd1;
	localparam action_t ACT_LIST   = 2'd2;

	// result status codes
	localparam status_t STAT_OK    = 2'd0;
	localparam status_t STAT_FULL  = 2'd1;
	localparam status_t STAT_EMPTY = 2'd2;

	// chain operations
	localparam op_t OP_HOLD = 2'd0;
	localparam op_t OP_INS  = 2'd1;
	localparam op_t OP_DEL  = 2'd2;
	localparam op_t OP_ROT  = 2'd3;

	typedef struct packed {
		op_t    op;
		value_t value;
	} chain_ctrl_t;

endpackage

// ----- design/spq_if.sv -----
interface spq_item_if import spq_pkg::*; ();
	logic    valid;
	logic    ready;
	action_t action;
	value_t  value;

	modport source (output valid, action, value, input ready);
	modport sink (input valid, action, value, output ready);
endinterface

interface spq_result_if import spq_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t status;
	value_t  value_out;
	logic    last;

	modport source (output valid, status, value_out, last, input ready);
	modport sink (input valid, status, value_out, last, output ready);
endinterface

// ----- design/spq_cell.sv -----
module spq_cell import spq_pkg::*; (
	input  logic        clk,
	input  chain_ctrl_t ctrl,
	input  logic        occupied,
	input  logic        tail,
	input  logic        prev_keep,
	input  value_t      prev_val,
	input  value_t      next_val,
	input  value_t      head_val,
	output logic        keep,
	output value_t      val
);

	value_t val_q;
	value_t val_d;

	// keep this entry when it is valid and not smaller than the new value
	assign keep = occupied && (val_q >= ctrl.value);
	assign val  = val_q;

	always_comb begin
		case (ctrl.op)
			OP_INS:  val_d = keep ? val_q : (prev_keep ? ctrl.value : prev_val);
			OP_DEL:  val_d = next_val;
			OP_ROT:  val_d = tail ? head_val : next_val;
			default: val_d = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

endmodule

// ----- design/sorted_priority_queue.sv -----
// Channel | Role  | Payload                         | Transfer when
// item    | sink  | action[1:0], value[31:0]        | item.valid && item.ready
// result  | source| status[1:0], value_out[31:0], last | result.valid && result.ready
//
// Insert and delete keep the block idle; a new item may follow in the next cycle
// if the output register is free. A list emits one result per stored entry (one
// when empty): the cell chain rotates its occupied prefix by one cell per cycle toward
// the free output register. Reset clears the state, entry count and output valid flag;
// the output payload and cell contents stay unknown and are never read until written.
// A stalled result holds in the output register; a list pauses its rotation.
module sorted_priority_queue import spq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	spq_item_if.sink      item,
	spq_result_if.source  result
);

	localparam int CW = $clog2(DEPTH + 1);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_LIST = 1'b1;

	logic          state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] rem_q, rem_d;

	logic    rvalid_q;
	status_t rstatus_q;
	value_t  rvalue_q;
	logic    rlast_q;

	logic    load;
	status_t nstatus;
	value_t  nvalue;
	logic    nlast;

	chain_ctrl_t ctrl;
	value_t      val_w  [DEPTH];
	logic        keep_w [DEPTH];

	logic free, acc, full, empty;

	// output register frees up when empty or when its result transfers
	assign free  = !rvalid_q || result.ready;
	assign item.ready = (state_q == S_IDLE) && free;
	assign acc   = item.valid && item.ready;
	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		rem_d      = rem_q;
		load       = 1'b0;
		nstatus    = STAT_OK;
		nvalue     = '0;
		nlast      = 1'b1;
		ctrl.op    = OP_HOLD;
		ctrl.value = item.value;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (item.action)
						ACT_INSERT: begin
							load = 1'b1;
							if (full) begin
								nstatus = STAT_FULL;
							end else begin
								nvalue  = item.value;
								ctrl.op = OP_INS;
								count_d = count_q + 1'b1;
							end
						end
						ACT_DELETE: begin
							load = 1'b1;
							if (empty) begin
								nstatus = STAT_EMPTY;
							end else begin
								nvalue  = val_w[0];
								ctrl.op = OP_DEL;
								count_d = count_q - 1'b1;
							end
						end
						ACT_LIST: begin
							load = 1'b1;
							if (empty) begin
								nstatus = STAT_EMPTY;
							end else begin
								// emit the head, rotate, and walk the rest
								nvalue  = val_w[0];
								nlast   = (count_q == CW'(1));
								ctrl.op = OP_ROT;
								rem_d   = count_q - 1'b1;
								if (count_q != CW'(1)) begin
									state_d = S_LIST;
								end
							end
						end
						default: ;  // unused code: drop silently
					endcase
				end
			end
			S_LIST: begin
				if (free) begin
					load    = 1'b1;
					nvalue  = val_w[0];
					nlast   = (rem_q == CW'(1));
					ctrl.op = OP_ROT;
					rem_d   = rem_q - 1'b1;
					if (rem_q == CW'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rem_q    <= '0;
			rvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			rem_q    <= rem_d;
			rvalid_q <= load ? 1'b1 : (rvalid_q && !result.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rstatus_q <= nstatus;
			rvalue_q  <= nvalue;
			rlast_q   <= nlast;
		end
	end

	assign result.valid     = rvalid_q;
	assign result.status    = rstatus_q;
	assign result.value_out = rvalue_q;
	assign result.last      = rlast_q;

	// The chain: cell 0 holds the largest entry. Each cell sees its neighbors
	// and the head, and occupancy/tail come from the entry count.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CW-1:0] IDX  = CW'(i);
		localparam logic [CW-1:0] IDX1 = CW'(i + 1);

		logic   prev_keep;
		value_t prev_val;
		value_t next_val;

		if (i == 0) begin : g_first
			assign prev_keep = 1'b1;
			assign prev_val  = ctrl.value;
		end else begin : g_mid
			assign prev_keep = keep_w[i-1];
			assign prev_val  = val_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign next_val = val_w[i];
		end else begin : g_inner
			assign next_val = val_w[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occupied  (IDX < count_q),
			.tail      (IDX1 == count_q),
			.prev_keep (prev_keep),
			.prev_val  (prev_val),
			.next_val  (next_val),
			.head_val  (val_w[0]),
			.keep      (keep_w[i]),
			.val       (val_w[i])
		);
	end

endmodule

// ----- design/spq_chk.sv -----
module spq_chk import spq_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    in_valid,
	input logic    in_ready,
	input action_t in_action,
	input logic    out_valid,
	input logic    out_ready,
	input status_t out_status,
	input value_t  out_value,
	input logic    out_last
);

	logic list_busy_q;

	// track a list request until its final result transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_busy_q <= 1'b0;
		end else if (in_valid && in_ready && in_action == ACT_LIST) begin
			list_busy_q <= 1'b1;
		end else if (out_valid && out_ready && out_last) begin
			list_busy_q <= 1'b0;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
		else $error("stalled result changed");

	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != STAT_OK |-> out_last && out_value == '0)
		else $error("error result not final or value nonzero");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_status == STAT_OK || out_status == STAT_FULL
		|| out_status == STAT_EMPTY)
		else $error("bad status code");

	a_no_accept_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !list_busy_q || (out_valid && out_ready && out_last))
		else $error("item taken while a list is still in progress");

endmodule

bind sorted_priority_queue spq_chk u_spq_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (item.valid),
	.in_ready   (item.ready),
	.in_action  (item.action),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_status (result.status),
	.out_value  (result.value_out),
	.out_last   (result.last)
);

// ----- sim/sorted_priority_queue_tb.sv -----
module sorted_priority_queue_tb import spq_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// Action code 3 is unused: the block drops it without a result.
	localparam action_t ACT_UNUSED = 2'd3;
	localparam value_t  VAL_MAX    = 32'sh7fff_ffff;
	localparam value_t  VAL_MIN    = 32'sh8000_0000;
	localparam int      RAND_ITEMS = 190;

	typedef struct packed {
		status_t status;
		value_t  value_out;
		logic    last;
	} result_rec_t;

	// Mirror of the queue contents plus the results still owed by the block.
	class pq_scoreboard;
		value_t      slots[DEPTH_DEF];
		int          fill;
		result_rec_t owed[$];
		int          errors;

		function new();
			fill   = 0;
			errors = 0;
		endfunction

		function void owe(status_t st, value_t v, logic lst);
			result_rec_t rec;
			rec.status    = st;
			rec.value_out = v;
			rec.last      = lst;
			owed.push_back(rec);
		endfunction

		// Update the mirror for one accepted request and queue its results.
		function void note_item(action_t act, value_t val);
			int pos;
			case (act)
				ACT_INSERT: begin
					if (fill == DEPTH_DEF) begin
						owe(STAT_FULL, '0, 1'b1);
					end else begin
						// shift smaller entries toward the tail; equal values stay ahead
						pos = fill;
						while (pos > 0 && slots[pos-1] < val) begin
							slots[pos] = slots[pos-1];
							pos--;
						end
						slots[pos] = val;
						fill++;
						owe(STAT_OK, val, 1'b1);
					end
				end
				ACT_DELETE: begin
					if (fill == 0) begin
						owe(STAT_EMPTY, '0, 1'b1);
					end else begin
						owe(STAT_OK, slots[0], 1'b1);
						for (int i = 1; i < fill; i++)
							slots[i-1] = slots[i];
						fill--;
					end
				end
				ACT_LIST: begin
					if (fill == 0)
						owe(STAT_EMPTY, '0, 1'b1);
					else
						for (int i = 0; i < fill; i++)
							owe(STAT_OK, slots[i], i == fill - 1);
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string msg);
			$display("ERROR at %0t ns: %s", $time, msg);
			errors++;
		endtask

		task check_result(status_t st, value_t v, logic lst);
			result_rec_t exp_rec;
			if (owed.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d value=%0d last=%0b",
					st, v, lst));
			end else begin
				exp_rec = owed.pop_front();
				if (st !== exp_rec.status)
					report_mismatch($sformatf("status %0d, expected %0d", st, exp_rec.status));
				if (v !== exp_rec.value_out)
					report_mismatch($sformatf("value_out %0d, expected %0d",
						v, exp_rec.value_out));
				if (lst !== exp_rec.last)
					report_mismatch($sformatf("last %0b, expected %0b", lst, exp_rec.last));
			end
		endtask

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	spq_item_if   item_ch();
	spq_result_if result_ch();

	sorted_priority_queue #(.DEPTH(DEPTH_DEF)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	pq_scoreboard book = new();

	// Random idling on both channels; cleared for a stretch of back-to-back traffic.
	bit idle_on   = 1'b1;
	// Cycles the result side still has to hold off, counted down by the receiver.
	int hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous limit, far beyond what the test needs.
	initial begin
		#2ms;
		$display("Simulation FAILED");
		$finish;
	end

	// Result side: drive ready at the falling edge, honoring any long hold-off.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= !(idle_on && $urandom_range(99) < 6);
			end
		end
	end

	// Check every result transfer against the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			book.check_result(result_ch.status, result_ch.value_out, result_ch.last);
	end

	// Offer one request and hold it until the block takes it. Returns at the
	// rising edge of the transfer, so the next request lines up on the next
	// falling edge with a single assignment to valid.
	task automatic send_item(input action_t act, input value_t val);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 6) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid  <= 1'b1;
		item_ch.action <= act;
		item_ch.value  <= val;
		do @(posedge clk); while (!item_ch.ready);
		book.note_item(act, val);
	endtask

	// Drop valid and wait until every owed result has come back.
	task automatic drain_results();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (book.pending() != 0)
			@(posedge clk);
	endtask

	// Mix of full-range, extreme and small values; small ones make duplicates likely.
	function automatic value_t pick_value();
		case ($urandom_range(9))
			0, 1, 2: return value_t'(int'($urandom_range(8)) - 4);
			3: begin
				case ($urandom_range(3))
					0: return VAL_MAX;
					1: return VAL_MIN;
					2: return '0;
					default: return -1;
				endcase
			end
			default: return value_t'($urandom);
		endcase
	endfunction

	initial begin
		int      ins_pct;
		int      r;
		action_t act;

		arst_n         = 1'b0;
		item_ch.valid  = 1'b0;
		item_ch.action = ACT_INSERT;
		item_ch.value  = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty queue corners and the unused code.
		send_item(ACT_DELETE, 32'sh1234_5678);
		send_item(ACT_LIST, VAL_MAX);
		send_item(ACT_UNUSED, VAL_MIN);
		// fill with extremes and ties
		send_item(ACT_INSERT, VAL_MAX);
		send_item(ACT_INSERT, VAL_MIN);
		send_item(ACT_INSERT, '0);
		send_item(ACT_INSERT, -1);
		send_item(ACT_INSERT, 1);
		send_item(ACT_INSERT, 5);
		send_item(ACT_INSERT, 5);
		send_item(ACT_INSERT, 32'sh5555_5555);
		// full queue refuses, then list and drain it completely
		send_item(ACT_INSERT, 32'shAAAA_AAAA);
		send_item(ACT_LIST, '0);
		for (int i = 0; i < DEPTH_DEF; i++)
			send_item(ACT_DELETE, '0);
		send_item(ACT_LIST, '0);
		send_item(ACT_DELETE, -1);

		// Sender pause: nothing new until every result is back.
		drain_results();

		// Hold the result side off while requests keep coming, so the block backs up.
		hold_left = 120;
		for (int i = 0; i < DEPTH_DEF + 2; i++)
			send_item(ACT_INSERT, pick_value());
		send_item(ACT_LIST, '0);
		for (int i = 0; i < 4; i++)
			send_item(ACT_DELETE, '0);
		drain_results();

		// Random traffic in blocks that lean toward filling, draining or neither.
		ins_pct = 50;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 16 == 0)
				ins_pct = ($urandom_range(2) == 0) ? 80 :
					($urandom_range(1) == 0) ? 25 : 50;
			idle_on = !(n >= 60 && n < 120);
			r = $urandom_range(99);
			if (r < 9)
				act = ACT_LIST;
			else if (r < 12)
				act = ACT_UNUSED;
			else
				act = ($urandom_range(99) < ins_pct) ? ACT_INSERT : ACT_DELETE;
			send_item(act, pick_value());
		end
		idle_on = 1'b1;

		drain_results();
		// settle: catch any stray result after the last owed one
		repeat (16) @(posedge clk);

		if (book.errors == 0 && book.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/spq_pkg.sv
design/spq_if.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
design/spq_chk.sv
sim/sorted_priority_queue_tb.sv
